### src/ifs_pkg.sv
// ----------------------------------------------------------------------------
// ifs_pkg
// Shared constants and types for the image fit scaler.
// ----------------------------------------------------------------------------
package ifs_pkg;

    localparam int MAX_SOURCE_WIDTH  = 256;
    localparam int MAX_SOURCE_HEIGHT = 256;
    localparam int MAX_SCREEN_SIDE   = 2048;
    localparam int MAX_BOX_SIDE      = 16;

    localparam int WEIGHT_ONE = 16384;
    localparam int WEIGHT_W   = 15;

    localparam int ADDR_W = 16;
    localparam int PIX_W  = 24;

    localparam int DIV_N_W = 32;
    localparam int DIV_D_W = 16;

    localparam int SIDE_W = 9;
    localparam int SCR_W  = 12;
    localparam int POS_W  = 11;
    localparam int OFF_W  = 20;
    localparam int STEP_W = 10;
    localparam int DEN_W  = 13;
    localparam int PROD_W = 21;
    localparam int NUM_W  = 24;
    localparam int CNT_W  = $clog2(MAX_BOX_SIDE * MAX_BOX_SIDE + 1);
    localparam int SUM_W  = 8 + CNT_W;

    localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd2;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd3;
    localparam logic [2:0] REG_FIT_STYLE     = 3'd4;
    localparam logic [2:0] REG_BACKGROUND    = 3'd5;

    localparam logic [1:0] STYLE_STRETCH = 2'd0;
    localparam logic [1:0] STYLE_FIT     = 2'd1;
    localparam logic [1:0] STYLE_CENTER  = 2'd2;
    localparam logic [1:0] STYLE_FILL    = 2'd3;

    typedef logic [PIX_W-1:0] pixel_t;

endpackage

### src/image_fit_scaler_top.sv
// ----------------------------------------------------------------------------
// image_fit_scaler_top
// Fits a stored source picture onto a screen and returns one pixel a request.
// ----------------------------------------------------------------------------
// Use:
//   The input channel (in_valid/in_ready) carries loads and requests. A load
//   (kind 0) writes load_pixel at load_address. A request (kind 1) names a
//   screen pixel; its colour and covered flag come out on the output channel
//   (out_valid/out_ready), one result per request.
//   Configuration is written through cfg_write/cfg_index/cfg_data while idle.
// Processing:
//   Each division runs on one shared 32-step divider. Enlarging requests
//   take up to 5 divisions. Shrinking requests take 7 or 8 divisions and
//   read one box pixel per cycle (up to MAX_BOX_SIDE squared pixels). One
//   request is worked on at a time.
// Reset:
//   Configuration and control registers take their reset values; store
//   contents stay undefined until loaded.
// Stalls:
//   A finished result waits in the output register; the next request may be
//   taken and worked on, and waits at its end until the output is free.
// ----------------------------------------------------------------------------
module image_fit_scaler_top
    import ifs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [2:0]        cfg_index,
    input  logic [23:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic [ADDR_W-1:0] load_address,
    input  pixel_t            load_pixel,
    input  logic [POS_W-1:0]  request_x,
    input  logic [POS_W-1:0]  request_y,
    output logic              out_valid,
    input  logic              out_ready,
    output pixel_t            pixel_colour,
    output logic              covered
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CHK   = 5'd1;
    localparam logic [4:0] S_PLACE = 5'd2;
    localparam logic [4:0] S_FIT   = 5'd3;
    localparam logic [4:0] S_COVER = 5'd4;
    localparam logic [4:0] S_MODE  = 5'd5;
    localparam logic [4:0] S_BX0   = 5'd6;
    localparam logic [4:0] S_BX1   = 5'd7;
    localparam logic [4:0] S_BX2   = 5'd8;
    localparam logic [4:0] S_BSET  = 5'd9;
    localparam logic [4:0] S_BRD   = 5'd10;
    localparam logic [4:0] S_BEND  = 5'd11;
    localparam logic [4:0] S_AVG   = 5'd12;
    localparam logic [4:0] S_AVGC  = 5'd13;
    localparam logic [4:0] S_L0    = 5'd14;
    localparam logic [4:0] S_L1    = 5'd15;
    localparam logic [4:0] S_L2    = 5'd16;
    localparam logic [4:0] S_L3    = 5'd17;
    localparam logic [4:0] S_L4    = 5'd18;
    localparam logic [4:0] S_L5    = 5'd19;
    localparam logic [4:0] S_LA    = 5'd20;
    localparam logic [4:0] S_LRD   = 5'd21;
    localparam logic [4:0] S_LEND  = 5'd22;
    localparam logic [4:0] S_B0    = 5'd23;
    localparam logic [4:0] S_B1    = 5'd24;
    localparam logic [4:0] S_OUT   = 5'd25;
    localparam logic [4:0] S_DIV   = 5'd26;

    // configuration
    logic [SIDE_W-1:0] sw_cfg_reg, sh_cfg_reg;
    logic [SCR_W-1:0]  wd_cfg_reg, ht_cfg_reg;
    logic [1:0]        style_reg;
    pixel_t            bg_reg;
    logic [SIDE_W-1:0] sw, sh;
    logic [SCR_W-1:0]  wd, ht;

    // control
    logic [4:0] state_reg, ret_reg;
    logic       axis_reg;
    logic [1:0] k_reg, cap_k_reg;
    logic       rd_pend_reg, rd_box_reg;
    logic       wide_reg;

    // datapath
    logic [POS_W-1:0]    rx_reg, ry_reg;
    logic [20:0]         pa_reg, pb_reg;
    logic [OFF_W-1:0]    off_reg   [2];
    logic [STEP_W-1:0]   step_reg  [2];
    logic [DEN_W-1:0]    den_reg   [2];
    logic [POS_W-1:0]    start_reg [2];
    logic [SCR_W-1:0]    len_reg   [2];
    logic [POS_W-1:0]    p_reg     [2];
    logic [PROD_W-1:0]   prod_reg  [2];
    logic [DIV_N_W-1:0]  lraw_reg;
    logic [SIDE_W-1:0]   lo_reg    [2];
    logic [SIDE_W-1:0]   hi_reg    [2];
    logic [SIDE_W-1:0]   col_reg, row_reg;
    logic [ADDR_W-1:0]   base_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [SUM_W-1:0]    sum_reg   [3];
    logic [NUM_W-1:0]    num_reg   [2];
    logic [SIDE_W-1:0]   i_reg     [2];
    logic [NUM_W-1:0]    t_reg;
    logic [WEIGHT_W-1:0] wt_reg    [2];
    logic [ADDR_W-1:0]   r0_reg, r1_reg;
    pixel_t              pix_reg   [4];
    logic [21:0]         top_reg, bot_reg;
    pixel_t              colour_reg;
    logic                out_valid_reg, covered_reg;
    pixel_t              out_colour_reg;

    // divider and store
    logic               div_start, div_done;
    logic [DIV_N_W-1:0] div_dvd, div_q;
    logic [DIV_D_W-1:0] div_dvs;
    logic               wr_en, rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    pixel_t             rd_data;

    function automatic logic [SIDE_W-1:0] sat_side(input logic [SIDE_W-1:0] v, input int mx);
        logic [SIDE_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = SIDE_W'(1);
        end
        else if (int'(v) > mx)
        begin
            r = SIDE_W'(mx);
        end
        return r;
    endfunction

    function automatic logic [SCR_W-1:0] sat_scr(input logic [SCR_W-1:0] v);
        logic [SCR_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = SCR_W'(1);
        end
        else if (int'(v) > MAX_SCREEN_SIDE)
        begin
            r = SCR_W'(MAX_SCREEN_SIDE);
        end
        return r;
    endfunction

    function automatic logic [2*SIDE_W-1:0] box_clamp(input logic [DIV_N_W-1:0] lr,
                                                      input logic [DIV_N_W-1:0] hr,
                                                      input logic [SIDE_W-1:0] side);
        logic [DIV_N_W-1:0] l, h, s;
        s = DIV_N_W'(side);
        l = (lr > s - 1) ? s - 1 : lr;
        h = hr;
        if (h <= l)
        begin
            h = l + 1;
        end
        if (h > s)
        begin
            h = s;
        end
        if (h - l > DIV_N_W'(MAX_BOX_SIDE))
        begin
            h = l + DIV_N_W'(MAX_BOX_SIDE);
        end
        return {h[SIDE_W-1:0], l[SIDE_W-1:0]};
    endfunction

    assign sw = sat_side(sw_cfg_reg, MAX_SOURCE_WIDTH);
    assign sh = sat_side(sh_cfg_reg, MAX_SOURCE_HEIGHT);
    assign wd = sat_scr(wd_cfg_reg);
    assign ht = sat_scr(ht_cfg_reg);

    logic [SIDE_W-1:0] side_a;
    logic [DEN_W:0]    d2_a;
    logic [NUM_W-1:0]  rem_a;
    logic [SIDE_W:0]   xi1_w, yi1_w;
    logic [SIDE_W-1:0] xi1, yi1;
    logic [SIDE_W-1:0] i_clamp;
    logic [2*SIDE_W-1:0] box_lh;
    logic [SCR_W-1:0]  fit_d;

    assign side_a  = axis_reg ? sh : sw;
    assign d2_a    = {den_reg[axis_reg], 1'b0};
    assign rem_a   = num_reg[axis_reg] - t_reg;
    assign xi1_w   = {1'b0, i_reg[0]} + 1'b1;
    assign yi1_w   = {1'b0, i_reg[1]} + 1'b1;
    assign xi1     = (xi1_w < {1'b0, sw}) ? xi1_w[SIDE_W-1:0] : i_reg[0];
    assign yi1     = (yi1_w < {1'b0, sh}) ? yi1_w[SIDE_W-1:0] : i_reg[1];
    assign i_clamp = (div_q >= DIV_N_W'(side_a) - 1)
                   ? ((side_a >= SIDE_W'(2)) ? side_a - SIDE_W'(2) : '0)
                   : div_q[SIDE_W-1:0];
    assign box_lh  = box_clamp(lraw_reg, div_q, side_a);
    assign fit_d   = div_q[SCR_W-1:0];

    always_comb
    begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;
        unique case (state_reg)
            S_PLACE:
            begin
                if (style_reg == STYLE_FIT)
                begin
                    div_start = 1'b1;
                    if (pa_reg <= pb_reg)
                    begin
                        div_dvd = DIV_N_W'({pa_reg, 1'b0}) + DIV_N_W'(sw);
                        div_dvs = DIV_D_W'({sw, 1'b0});
                    end
                    else
                    begin
                        div_dvd = DIV_N_W'({pb_reg, 1'b0}) + DIV_N_W'(sh);
                        div_dvs = DIV_D_W'({sh, 1'b0});
                    end
                end
            end
            S_BX0:
            begin
                div_start = 1'b1;
                div_dvd   = DIV_N_W'(off_reg[axis_reg]) + DIV_N_W'(prod_reg[axis_reg]);
                div_dvs   = DIV_D_W'(den_reg[axis_reg]);
            end
            S_BX1:
            begin
                div_start = 1'b1;
                div_dvd   = DIV_N_W'(off_reg[axis_reg]) + DIV_N_W'(prod_reg[axis_reg])
                          + DIV_N_W'(step_reg[axis_reg]);
                div_dvs   = DIV_D_W'(den_reg[axis_reg]);
            end
            S_AVG:
            begin
                div_start = 1'b1;
                div_dvd   = DIV_N_W'(sum_reg[k_reg]);
                div_dvs   = DIV_D_W'(cnt_reg);
            end
            S_L1:
            begin
                div_start = 1'b1;
                div_dvd   = DIV_N_W'(num_reg[axis_reg]);
                div_dvs   = DIV_D_W'(d2_a);
            end
            S_L4:
            begin
                if (rem_a < NUM_W'(d2_a))
                begin
                    div_start = 1'b1;
                    div_dvd   = DIV_N_W'({rem_a, 14'd0});
                    div_dvs   = DIV_D_W'(d2_a);
                end
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);
    assign wr_en    = in_valid && in_ready && !kind;
    assign rd_en    = (state_reg == S_BRD) || (state_reg == S_LRD);

    always_comb
    begin
        if (state_reg == S_BRD)
        begin
            rd_addr = base_reg + ADDR_W'(col_reg);
        end
        else
        begin
            rd_addr = (k_reg[1] ? r1_reg : r0_reg) + ADDR_W'(k_reg[0] ? xi1 : i_reg[0]);
        end
    end

    logic [NUM_W-1:0] nsum [2];
    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            nsum[a] = NUM_W'({off_reg[a], 1'b0}) + NUM_W'(prod_reg[a]);
        end
    end

    logic [37:0] blend;
    logic [9:0]  chan;
    assign blend = 38'(top_reg) * 38'(WEIGHT_ONE - int'(wt_reg[1]))
                 + 38'(bot_reg) * 38'(wt_reg[1]) + (38'd1 << 27);
    assign chan  = blend[37:28];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_cfg_reg    <= SIDE_W'(256);
            sh_cfg_reg    <= SIDE_W'(256);
            wd_cfg_reg    <= SCR_W'(1024);
            ht_cfg_reg    <= SCR_W'(768);
            style_reg     <= STYLE_FILL;
            bg_reg        <= '0;
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            axis_reg      <= 1'b0;
            k_reg         <= '0;
            cap_k_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            rd_box_reg    <= 1'b0;
            wide_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_SOURCE_WIDTH:  sw_cfg_reg <= cfg_data[SIDE_W-1:0];
                    REG_SOURCE_HEIGHT: sh_cfg_reg <= cfg_data[SIDE_W-1:0];
                    REG_SCREEN_WIDTH:  wd_cfg_reg <= cfg_data[SCR_W-1:0];
                    REG_SCREEN_HEIGHT: ht_cfg_reg <= cfg_data[SCR_W-1:0];
                    REG_FIT_STYLE:     style_reg  <= cfg_data[1:0];
                    REG_BACKGROUND:    bg_reg     <= cfg_data;
                    default:           bg_reg     <= bg_reg;
                endcase
            end

            rd_pend_reg <= rd_en;
            rd_box_reg  <= (state_reg == S_BRD);
            cap_k_reg   <= k_reg;
            if (rd_pend_reg)
            begin
                if (rd_box_reg)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        sum_reg[c] <= sum_reg[c] + SUM_W'(rd_data[8*c +: 8]);
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
                else
                begin
                    pix_reg[cap_k_reg] <= rd_data;
                end
            end

            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && kind)
                    begin
                        rx_reg    <= request_x;
                        ry_reg    <= request_y;
                        state_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    colour_reg  <= bg_reg;
                    covered_reg <= 1'b0;
                    pa_reg      <= 21'(wd) * 21'(sh);
                    pb_reg      <= 21'(ht) * 21'(sw);
                    if (SCR_W'(rx_reg) >= wd || SCR_W'(ry_reg) >= ht)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_PLACE;
                    end
                end
                S_PLACE:
                begin
                    wide_reg <= (pa_reg <= pb_reg);
                    for (int a = 0; a < 2; a++)
                    begin
                        off_reg[a]   <= '0;
                        start_reg[a] <= '0;
                    end
                    len_reg[0] <= wd;
                    len_reg[1] <= ht;
                    state_reg  <= S_COVER;
                    unique case (style_reg)
                        STYLE_STRETCH:
                        begin
                            step_reg[0] <= STEP_W'({sw, 1'b0});
                            den_reg[0]  <= DEN_W'({wd, 1'b0});
                            step_reg[1] <= STEP_W'({sh, 1'b0});
                            den_reg[1]  <= DEN_W'({ht, 1'b0});
                        end
                        STYLE_FIT:
                        begin
                            ret_reg   <= S_FIT;
                            state_reg <= S_DIV;
                        end
                        STYLE_CENTER:
                        begin
                            if (SCR_W'(sw) < wd)
                            begin
                                off_reg[0]   <= '0;
                                start_reg[0] <= POS_W'((wd - SCR_W'(sw)) >> 1);
                                len_reg[0]   <= SCR_W'(sw);
                            end
                            else
                            begin
                                off_reg[0]   <= OFF_W'(SCR_W'(sw) - wd);
                                start_reg[0] <= '0;
                                len_reg[0]   <= wd;
                            end
                            if (SCR_W'(sh) < ht)
                            begin
                                off_reg[1]   <= '0;
                                start_reg[1] <= POS_W'((ht - SCR_W'(sh)) >> 1);
                                len_reg[1]   <= SCR_W'(sh);
                            end
                            else
                            begin
                                off_reg[1]   <= OFF_W'(SCR_W'(sh) - ht);
                                start_reg[1] <= '0;
                                len_reg[1]   <= ht;
                            end
                            step_reg[0] <= STEP_W'(2);
                            den_reg[0]  <= DEN_W'(2);
                            step_reg[1] <= STEP_W'(2);
                            den_reg[1]  <= DEN_W'(2);
                        end
                        STYLE_FILL:
                        begin
                            if (pa_reg > pb_reg)
                            begin
                                step_reg[0] <= STEP_W'({sw, 1'b0});
                                den_reg[0]  <= DEN_W'({wd, 1'b0});
                                off_reg[1]  <= OFF_W'(pa_reg - pb_reg);
                                step_reg[1] <= STEP_W'({sw, 1'b0});
                                den_reg[1]  <= DEN_W'({wd, 1'b0});
                            end
                            else
                            begin
                                off_reg[0]  <= OFF_W'(pb_reg - pa_reg);
                                step_reg[0] <= STEP_W'({sh, 1'b0});
                                den_reg[0]  <= DEN_W'({ht, 1'b0});
                                step_reg[1] <= STEP_W'({sh, 1'b0});
                                den_reg[1]  <= DEN_W'({ht, 1'b0});
                            end
                        end
                        default:
                        begin
                            state_reg <= S_COVER;
                        end
                    endcase
                end
                S_FIT:
                begin
                    step_reg[0] <= STEP_W'({sw, 1'b0});
                    step_reg[1] <= STEP_W'({sh, 1'b0});
                    if (fit_d == '0)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_COVER;
                    end
                    if (wide_reg)
                    begin
                        den_reg[0]   <= DEN_W'({wd, 1'b0});
                        len_reg[0]   <= wd;
                        den_reg[1]   <= DEN_W'({fit_d, 1'b0});
                        start_reg[1] <= POS_W'((ht - fit_d) >> 1);
                        len_reg[1]   <= fit_d;
                    end
                    else
                    begin
                        den_reg[0]   <= DEN_W'({fit_d, 1'b0});
                        start_reg[0] <= POS_W'((wd - fit_d) >> 1);
                        len_reg[0]   <= fit_d;
                        den_reg[1]   <= DEN_W'({ht, 1'b0});
                        len_reg[1]   <= ht;
                    end
                end
                S_COVER:
                begin
                    p_reg[0] <= rx_reg - start_reg[0];
                    p_reg[1] <= ry_reg - start_reg[1];
                    if (rx_reg < start_reg[0] || ry_reg < start_reg[1]
                        || SCR_W'(rx_reg - start_reg[0]) >= len_reg[0]
                        || SCR_W'(ry_reg - start_reg[1]) >= len_reg[1])
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_MODE;
                    end
                end
                S_MODE:
                begin
                    axis_reg <= 1'b0;
                    if (DEN_W'(step_reg[0]) >= den_reg[0] || DEN_W'(step_reg[1]) >= den_reg[1])
                    begin
                        for (int a = 0; a < 2; a++)
                        begin
                            prod_reg[a] <= PROD_W'(p_reg[a]) * PROD_W'(step_reg[a]);
                        end
                        state_reg <= S_BX0;
                    end
                    else
                    begin
                        for (int a = 0; a < 2; a++)
                        begin
                            prod_reg[a] <= PROD_W'({p_reg[a], 1'b1}) * PROD_W'(step_reg[a]);
                        end
                        state_reg <= S_L0;
                    end
                end
                S_BX0:
                begin
                    ret_reg   <= S_BX1;
                    state_reg <= S_DIV;
                end
                S_BX1:
                begin
                    lraw_reg  <= div_q;
                    ret_reg   <= S_BX2;
                    state_reg <= S_DIV;
                end
                S_BX2:
                begin
                    lo_reg[axis_reg] <= box_lh[SIDE_W-1:0];
                    hi_reg[axis_reg] <= box_lh[2*SIDE_W-1:SIDE_W];
                    if (!axis_reg)
                    begin
                        axis_reg  <= 1'b1;
                        state_reg <= S_BX0;
                    end
                    else
                    begin
                        state_reg <= S_BSET;
                    end
                end
                S_BSET:
                begin
                    base_reg <= ADDR_W'(18'(lo_reg[1]) * 18'(sw));
                    col_reg  <= lo_reg[0];
                    row_reg  <= lo_reg[1];
                    cnt_reg  <= '0;
                    for (int c = 0; c < 3; c++)
                    begin
                        sum_reg[c] <= '0;
                    end
                    state_reg <= S_BRD;
                end
                S_BRD:
                begin
                    if (col_reg + 1'b1 == hi_reg[0])
                    begin
                        col_reg <= lo_reg[0];
                        if (row_reg + 1'b1 == hi_reg[1])
                        begin
                            state_reg <= S_BEND;
                        end
                        else
                        begin
                            row_reg  <= row_reg + 1'b1;
                            base_reg <= base_reg + ADDR_W'(sw);
                        end
                    end
                    else
                    begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
                S_BEND:
                begin
                    k_reg     <= '0;
                    state_reg <= S_AVG;
                end
                S_AVG:
                begin
                    ret_reg   <= S_AVGC;
                    state_reg <= S_DIV;
                end
                S_AVGC:
                begin
                    colour_reg[8*k_reg +: 8] <= div_q[7:0];
                    if (k_reg == 2'd2)
                    begin
                        covered_reg <= 1'b1;
                        state_reg   <= S_OUT;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_AVG;
                    end
                end
                S_L0:
                begin
                    for (int a = 0; a < 2; a++)
                    begin
                        num_reg[a] <= (nsum[a] < NUM_W'(den_reg[a])) ? '0
                                    : nsum[a] - NUM_W'(den_reg[a]);
                    end
                    state_reg <= S_L1;
                end
                S_L1:
                begin
                    ret_reg   <= S_L2;
                    state_reg <= S_DIV;
                end
                S_L2:
                begin
                    i_reg[axis_reg] <= i_clamp;
                    state_reg       <= S_L3;
                end
                S_L3:
                begin
                    t_reg     <= NUM_W'(NUM_W'(i_reg[axis_reg]) * NUM_W'(d2_a));
                    state_reg <= S_L4;
                end
                S_L4:
                begin
                    if (rem_a < NUM_W'(d2_a))
                    begin
                        ret_reg   <= S_L5;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        wt_reg[axis_reg] <= WEIGHT_W'(WEIGHT_ONE);
                        axis_reg         <= 1'b1;
                        state_reg        <= axis_reg ? S_LA : S_L1;
                    end
                end
                S_L5:
                begin
                    wt_reg[axis_reg] <= (div_q > DIV_N_W'(WEIGHT_ONE))
                                      ? WEIGHT_W'(WEIGHT_ONE) : div_q[WEIGHT_W-1:0];
                    axis_reg         <= 1'b1;
                    state_reg        <= axis_reg ? S_LA : S_L1;
                end
                S_LA:
                begin
                    r0_reg    <= ADDR_W'(18'(i_reg[1]) * 18'(sw));
                    r1_reg    <= ADDR_W'(18'(yi1) * 18'(sw));
                    k_reg     <= '0;
                    state_reg <= S_LRD;
                end
                S_LRD:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 2'd3)
                    begin
                        state_reg <= S_LEND;
                    end
                end
                S_LEND:
                begin
                    k_reg     <= '0;
                    state_reg <= S_B0;
                end
                S_B0:
                begin
                    top_reg <= 22'(pix_reg[0][8*k_reg +: 8]) * 22'(WEIGHT_ONE - int'(wt_reg[0]))
                             + 22'(pix_reg[1][8*k_reg +: 8]) * 22'(wt_reg[0]);
                    bot_reg <= 22'(pix_reg[2][8*k_reg +: 8]) * 22'(WEIGHT_ONE - int'(wt_reg[0]))
                             + 22'(pix_reg[3][8*k_reg +: 8]) * 22'(wt_reg[0]);
                    state_reg <= S_B1;
                end
                S_B1:
                begin
                    colour_reg[8*k_reg +: 8] <= (chan > 10'd255) ? 8'hFF : chan[7:0];
                    if (k_reg == 2'd2)
                    begin
                        covered_reg <= 1'b1;
                        state_reg   <= S_OUT;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_B0;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_colour_reg <= colour_reg;
                        covered        <= covered_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ret_reg;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_colour = out_colour_reg;

    ifs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    ifs_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (load_address),
        .wr_data (load_pixel),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

### src/ifs_div.sv
// ----------------------------------------------------------------------------
// ifs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ifs_div
    import ifs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic               done,
    output logic [DIV_N_W-1:0] quotient
);

    localparam int CW = $clog2(DIV_N_W);

    logic               busy_reg;
    logic               done_reg;
    logic [CW-1:0]      cnt_reg;
    logic [DIV_N_W-1:0] quo_reg;
    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_D_W-1:0] dvs_reg;
    logic [DIV_D_W:0]   trial;
    logic               fits;

    assign trial = {rem_reg, quo_reg[DIV_N_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(DIV_N_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? DIV_D_W'(trial - {1'b0, dvs_reg}) : trial[DIV_D_W-1:0];
                quo_reg <= {quo_reg[DIV_N_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DIV_N_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### src/ifs_store.sv
// ----------------------------------------------------------------------------
// ifs_store
// Source picture store, one write and one registered read port.
// ----------------------------------------------------------------------------
module ifs_store
    import ifs_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  pixel_t            wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output pixel_t            rd_data
);

    pixel_t mem [0:(1 << ADDR_W) - 1];
    pixel_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
